FILE: rtl/lsdp_pkg.sv
// Package for the LRU stack distance profiler: payload words, queue entry,
// configuration struct, back-end state type and sizing constants. No dependencies.
`timescale 1ns / 1ps
package lsdp_pkg;
   localparam int STACK_DEPTH_DEF = 256;
   localparam int SET_BITS_DEF    = 8;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = 2;
   localparam int LINE_W          = 44;
   localparam int OWNER_W         = 8;
   localparam int TOTAL_W         = 48;

   localparam logic REG_LINE_SIZE = 1'b0;
   localparam logic REG_OWNER     = 1'b1;

   typedef struct packed {
      logic [47:0] base_addr;
      logic [6:0]  num_bytes;
      logic [7:0]  requester_id;
   } req_type;

   typedef struct packed {
      logic [43:0] line_addr;
      logic        hit;
      logic [2:0]  set_bits_index;
      logic [8:0]  distance;
      logic        remote;
      logic [47:0] access_total;
      logic [47:0] cold_miss_total;
      logic [47:0] unaligned_total;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [LINE_W-1:0]  line;
      logic [OWNER_W-1:0] rid;
      logic               last;
      logic [TOTAL_W-1:0] acc_tot;
      logic [TOTAL_W-1:0] una_tot;
   } job_type;

   typedef struct packed {
      logic [3:0] line_size_log2;
      logic       record_owner;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HIT,
      ST_MISS
   } state_type;
endpackage

FILE: rtl/lsdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lsdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/lsdp_front.sv
// Front end: accepts access words, splits them into lines and keeps the
// access and unaligned totals. Depends on lsdp_pkg.
`timescale 1ns / 1ps
module lsdp_front (
   input  logic             clock,
   input  logic             reset,
   input  lsdp_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  lsdp_pkg::req_type req_data,
   output logic             push,
   output lsdp_pkg::job_type push_job,
   input  logic             q_full
);
   import lsdp_pkg::*;

   logic               busy_ff, busy_in;
   logic [2:0]         k_ff, k_in;
   logic [2:0]         nl_ff, nl_in;
   logic [LINE_W-1:0]  first_ff, first_in;
   logic [OWNER_W-1:0] rid_ff, rid_in;
   logic [TOTAL_W-1:0] acc_ff, acc_in;
   logic [TOTAL_W-1:0] una_ff, una_in;

   logic [3:0]  lg_c;
   logic [6:0]  n_c;
   logic [11:0] off;
   logic [12:0] span;
   logic [12:0] lsize;
   logic [2:0]  nl;
   logic [2:0]  whole;
   logic [LINE_W-1:0] lmask;
   logic        accept;

   always_comb begin
      lg_c  = (cfg.line_size_log2 < 4'd4) ? 4'd4 :
              (cfg.line_size_log2 > 4'd12) ? 4'd12 : cfg.line_size_log2;
      n_c   = (req_data.num_bytes == 7'd0) ? 7'd1 :
              (req_data.num_bytes > 7'd64) ? 7'd64 : req_data.num_bytes;
      off   = req_data.base_addr[11:0] & ~(12'hFFF << lg_c);
      lsize = 13'd1 << lg_c;
      span  = 13'(off) + 13'(n_c) - 13'd1;
      nl    = 3'((span >> lg_c) + 13'd1);
      whole = 3'((13'(n_c) + lsize - 13'd1) >> lg_c);
      lmask = {LINE_W{1'b1}} >> (lg_c - 4'd4);
   end

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign push      = busy_ff && !q_full;

   always_comb begin
      push_job.line    = (first_ff + LINE_W'(k_ff)) & lmask;
      push_job.rid     = rid_ff;
      push_job.last    = (k_ff == nl_ff - 3'd1);
      push_job.acc_tot = acc_ff;
      push_job.una_tot = una_ff;
   end

   always_comb begin
      busy_in  = busy_ff;
      k_in     = k_ff;
      nl_in    = nl_ff;
      first_in = first_ff;
      rid_in   = rid_ff;
      acc_in   = acc_ff;
      una_in   = una_ff;
      if (accept) begin
         busy_in  = 1'b1;
         k_in     = 3'd0;
         nl_in    = nl;
         first_in = LINE_W'(req_data.base_addr >> lg_c);
         rid_in   = req_data.requester_id;
         acc_in   = acc_ff + TOTAL_W'(nl);
         if (nl != 3'd1) begin
            una_in = una_ff + TOTAL_W'(nl - whole);
         end
      end else if (push) begin
         k_in = k_ff + 3'd1;
         if (push_job.last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         acc_ff  <= '0;
         una_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         acc_ff  <= acc_in;
         una_ff  <= una_in;
      end
      k_ff     <= k_in;
      nl_ff    <= nl_in;
      first_ff <= first_in;
      rid_ff   <= rid_in;
   end
endmodule

FILE: rtl/lsdp_queue.sv
// Short line queue between front and back end.
// Depends on lsdp_pkg.
`timescale 1ns / 1ps
module lsdp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lsdp_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output lsdp_pkg::job_type head
);
   import lsdp_pkg::*;

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wp_ff, wp_in;
   logic [QPTR_W-1:0] rp_ff, rp_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= push_job;
      end
   end
endmodule

FILE: rtl/lsdp_back.sv
// Back end: walks the LRU stack for each queued line, moves it to the top
// and emits results. Depends on lsdp_pkg and lsdp_ram.
`timescale 1ns / 1ps
module lsdp_back #(
   parameter int STACK_DEPTH = lsdp_pkg::STACK_DEPTH_DEF,
   parameter int SET_BITS    = lsdp_pkg::SET_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  lsdp_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  lsdp_pkg::job_type q_head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lsdp_pkg::rsp_type rsp_data
);
   import lsdp_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int FW = $clog2(STACK_DEPTH + 1);
   localparam int DW = FW;
   localparam int SW = (SET_BITS > 1) ? $clog2(SET_BITS) : 1;
   localparam int EW = LINE_W + OWNER_W;

   state_type state_ff, state_in;
   job_type            job_ff, job_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [EW-1:0]      carry_ff, carry_in;
   logic [DW-1:0]      dist_ff [SET_BITS];
   logic [DW-1:0]      dist_in [SET_BITS];
   logic [SW-1:0]      s_ff, s_in;
   logic               rem_ff, rem_in;
   logic [TOTAL_W-1:0] cold_ff, cold_in;
   logic               ov_ff, ov_in;
   rsp_type            out_ff, out_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] rd_data;
   logic [LINE_W-1:0]  e_line;
   logic [OWNER_W-1:0] e_owner;
   logic          can_load, found, at_end;
   logic [SET_BITS-1:0] agree;

   lsdp_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (carry_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign e_line   = rd_data[EW-1:OWNER_W];
   assign e_owner  = rd_data[OWNER_W-1:0];
   assign can_load = !ov_ff || rsp_ready;
   assign found    = (e_line == job_ff.line);
   assign at_end   = (FW'(idx_ff) + FW'(1) == fill_ff);
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      for (int s = 0; s < SET_BITS; s++) begin
         agree[s] = (((e_line ^ job_ff.line) & LINE_W'((64'd1 << s) - 64'd1)) == '0);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = (fill_ff == '0) ? ST_MISS : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (found) begin
               state_in = ST_HIT;
            end else if (at_end) begin
               state_in = ST_MISS;
            end
         end
         ST_HIT: begin
            if (can_load && s_ff == SW'(SET_BITS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_MISS: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      fill_in  = fill_ff;
      carry_in = carry_ff;
      dist_in  = dist_ff;
      s_in     = s_ff;
      rem_in   = rem_ff;
      cold_in  = cold_ff;
      ov_in    = ov_ff && !rsp_ready;
      out_in   = out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               job_in   = q_head;
               idx_in   = '0;
               s_in     = '0;
               carry_in = {q_head.line, q_head.rid};
               for (int s = 0; s < SET_BITS; s++) begin
                  dist_in[s] = '0;
               end
            end
         end
         ST_SCAN: begin
            wr_en    = 1'b1;
            carry_in = rd_data;
            for (int s = 0; s < SET_BITS; s++) begin
               dist_in[s] = dist_ff[s] + DW'(agree[s]);
            end
            rem_in  = cfg.record_owner && (e_owner != job_ff.rid);
            rd_en   = 1'b1;
            rd_addr = idx_ff + AW'(1);
            idx_in  = idx_ff + AW'(1);
         end
         ST_HIT: begin
            if (can_load) begin
               ov_in                  = 1'b1;
               out_in.line_addr       = job_ff.line;
               out_in.hit             = 1'b1;
               out_in.set_bits_index  = 3'(s_ff);
               out_in.distance        = 9'(dist_ff[s_ff]);
               out_in.remote          = rem_ff;
               out_in.access_total    = job_ff.acc_tot;
               out_in.cold_miss_total = cold_ff;
               out_in.unaligned_total = job_ff.una_tot;
               out_in.last            = job_ff.last && (s_ff == SW'(SET_BITS - 1));
               s_in                   = s_ff + SW'(1);
            end
         end
         ST_MISS: begin
            if (can_load) begin
               wr_addr = fill_ff[AW-1:0];
               if (fill_ff != FW'(STACK_DEPTH)) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end
               cold_in                = cold_ff + TOTAL_W'(1);
               ov_in                  = 1'b1;
               out_in.line_addr       = job_ff.line;
               out_in.hit             = 1'b0;
               out_in.set_bits_index  = '0;
               out_in.distance        = '0;
               out_in.remote          = 1'b0;
               out_in.access_total    = job_ff.acc_tot;
               out_in.cold_miss_total = cold_ff + TOTAL_W'(1);
               out_in.unaligned_total = job_ff.una_tot;
               out_in.last            = job_ff.last;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         cold_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cold_ff  <= cold_in;
         ov_ff    <= ov_in;
      end
      job_ff   <= job_in;
      idx_ff   <= idx_in;
      carry_ff <= carry_in;
      dist_ff  <= dist_in;
      s_ff     <= s_in;
      rem_ff   <= rem_in;
      out_ff   <= out_in;
   end
endmodule

FILE: rtl/lru_stack_distance_profiler_core.sv
// Each line leaves the queue, then the back end reads the stack entries in order (up to the
// current fill, stopping at a hit), then emits its results: SET_BITS words on a hit, one
// on a miss; results leave through one output register.
// An access word spans up to five lines; a new word is accepted only once all lines
// of the previous one are queued, so the stack walk sets the pace.
// Reset (synchronous): stack empty, totals zero, line size 64 bytes, owner flagging off.
`timescale 1ns / 1ps
module lru_stack_distance_profiler_core #(
   parameter int STACK_DEPTH = lsdp_pkg::STACK_DEPTH_DEF,
   parameter int SET_BITS    = lsdp_pkg::SET_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lsdp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lsdp_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import lsdp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push, q_full, pop, q_empty;
   job_type push_job, q_head;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_OWNER) ? {31'd0, cfg_ff.record_owner}
                                           : {28'd0, cfg_ff.line_size_log2};

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite && pready) begin
         if (paddr[2] == REG_LINE_SIZE) begin
            cfg_in.line_size_log2 = pwdata[3:0];
         end else begin
            cfg_in.record_owner = pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_size_log2 <= 4'd6;
         cfg_ff.record_owner   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsdp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_job  (push_job),
      .q_full    (q_full)
   );

   lsdp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   lsdp_back #(.STACK_DEPTH(STACK_DEPTH), .SET_BITS(SET_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

FILE: rtl/lsdp_checker.sv
// Port-level checks for the profiler core, bound to the top level.
// Depends on lsdp_pkg and lru_stack_distance_profiler_core.
`timescale 1ns / 1ps
module lsdp_checker #(
   parameter int SET_BITS = lsdp_pkg::SET_BITS_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lsdp_pkg::rsp_type rsp_data
);
   import lsdp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before accept");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result word changed while stalled");

   a_ready_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_ready)
      else $error("input not ready after reset");

   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |->
         rsp_data.distance == 9'd0 && rsp_data.set_bits_index == 3'd0 && !rsp_data.remote)
      else $error("miss word carries distance data");

   a_hit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit && rsp_data.last |->
         rsp_data.set_bits_index == 3'(SET_BITS - 1) && rsp_data.distance != 9'd0)
      else $error("hit sequence closed at wrong set count");
endmodule

bind lru_stack_distance_profiler_core lsdp_checker #(.SET_BITS(SET_BITS)) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
